// ===== rtl/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the LED scan, key debounce and ticker unit.
// ----------------------------------------------------------------------------
package lsd_pkg;

	localparam int ROWS_DEFAULT = 8;
	localparam int ROWS_MAX     = 16;

	localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
	localparam logic [7:0] PRESCALE_RESET = 8'd50;
	localparam logic [1:0] KEYS_RELEASED  = 2'b11;

	typedef enum logic [2:0] {
		FUNC_TICK        = 3'd0,
		FUNC_WRITE_ROW   = 3'd1,
		FUNC_LOAD_DELAY  = 3'd2,
		FUNC_START_TONE  = 3'd3,
		FUNC_READ_RANDOM = 3'd4
	} lsd_func_t;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE_LIMIT = 1'b0,
		CFG_PRESCALE_TICKS = 1'b1
	} lsd_cfg_idx_t;

	// Result word minus the column pattern, which comes from the row memory.
	typedef struct packed {
		logic [7:0] row_drive;
		logic [1:0] key_state;
		logic       user_tick;
		logic [7:0] delay_left;
		logic       tone_enable;
		logic [7:0] tone_period;
		logic [7:0] random_value;
	} lsd_result_t;

endpackage

// ===== rtl/lsd_row_mem.sv =====
// ----------------------------------------------------------------------------
// lsd_row_mem
// Column pattern memory, one entry per LED row, registered read with a
// write-to-read bypass and per-entry valid bits that reset clears.
// ----------------------------------------------------------------------------
module lsd_row_mem
	import lsd_pkg::*;
#(
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(ROWS)-1:0]  waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(ROWS)-1:0]  raddr,
	output logic [7:0]               rdata
);

	logic [7:0]      mem [ROWS];
	logic [ROWS-1:0] entry_valid_q;
	logic [7:0]      rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (we) begin
			entry_valid_q[waddr] <= 1'b1;
		end
	end

	// A write in the same cycle to the row being read wins.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && waddr == raddr) begin
				rdata_q <= wdata;
			end else if (entry_valid_q[raddr]) begin
				rdata_q <= mem[raddr];
			end else begin
				rdata_q <= 8'h00;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsd_ctrl
// Scan row, key debounce, random byte, prescaler, countdowns and the two
// configuration registers. Gives the next scan row and the result word.
// ----------------------------------------------------------------------------
module lsd_ctrl
	import lsd_pkg::*;
#(
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [2:0]               func,
	input  logic [1:0]               pin_sample,
	input  logic [7:0]               data_value,
	input  logic [7:0]               tone_value,
	input  logic                     cfg_we,
	input  logic                     cfg_sel,
	input  logic [7:0]               cfg_data,
	output logic [$clog2(ROWS)-1:0]  scan_next,
	output lsd_result_t              result
);

	localparam int AW = $clog2(ROWS);
	localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

	logic [7:0]    debounce_limit_q, prescale_ticks_q;
	logic [AW-1:0] scan_q, scan_n;
	logic [1:0]    stable_q, stable_n, cand_q, cand_n, keys_q, keys_n;
	logic [7:0]    agree_q, agree_n, rnd_q, rnd_n;
	logic [7:0]    pres_q, pres_n, delay_q, delay_n, length_q, length_n;
	logic          tone_on_q, tone_on_n;
	logic [7:0]    tone_q, tone_n;
	logic          wrap;
	logic [7:0]    rnd_out;
	logic [ROWS_MAX-1:0] sel;

	always_comb begin
		scan_n    = scan_q;
		stable_n  = stable_q;
		cand_n    = cand_q;
		keys_n    = keys_q;
		agree_n   = agree_q;
		rnd_n     = rnd_q;
		pres_n    = pres_q;
		delay_n   = delay_q;
		length_n  = length_q;
		tone_on_n = tone_on_q;
		tone_n    = tone_q;
		wrap      = 1'b0;
		rnd_out   = 8'h00;
		case (lsd_func_t'(func))
			FUNC_TICK: begin
				scan_n = (scan_q == LAST_ROW) ? '0 : scan_q + AW'(1);
				if (pin_sample != stable_q) begin
					if (pin_sample == cand_q) begin
						agree_n = agree_q + 8'd1;
						if (agree_n > debounce_limit_q) begin
							stable_n = cand_q;
							keys_n   = ~cand_q;
						end
					end else begin
						cand_n  = pin_sample;
						agree_n = 8'd0;
					end
					// stir with the new row and the updated key bits
					rnd_n = rnd_q + 8'(scan_n) + {6'd0, keys_n};
				end
				pres_n = pres_q + 8'd1;
				if (pres_n >= prescale_ticks_q) begin
					pres_n = 8'd0;
					wrap   = 1'b1;
					if (delay_q != 8'd0) begin
						delay_n = delay_q - 8'd1;
					end
					if (length_q != 8'd0) begin
						length_n = length_q - 8'd1;
						if (length_n == 8'd0) begin
							tone_on_n = 1'b0;
						end
					end
				end
			end
			FUNC_LOAD_DELAY: begin
				delay_n = data_value;
			end
			FUNC_START_TONE: begin
				tone_n    = tone_value;
				length_n  = data_value;
				tone_on_n = 1'b1;
			end
			FUNC_READ_RANDOM: begin
				rnd_n   = rnd_q + 8'd1;
				rnd_out = rnd_n ^ {rnd_n[6:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= DEBOUNCE_RESET;
			prescale_ticks_q <= PRESCALE_RESET;
		end else if (cfg_we) begin
			case (lsd_cfg_idx_t'(cfg_sel))
				CFG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_data;
				CFG_PRESCALE_TICKS: prescale_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			stable_q  <= KEYS_RELEASED;
			cand_q    <= KEYS_RELEASED;
			keys_q    <= 2'b00;
			agree_q   <= 8'd0;
			rnd_q     <= 8'd0;
			pres_q    <= 8'd0;
			delay_q   <= 8'd0;
			length_q  <= 8'd0;
			tone_on_q <= 1'b0;
			tone_q    <= 8'd0;
		end else if (accept) begin
			scan_q    <= scan_n;
			stable_q  <= stable_n;
			cand_q    <= cand_n;
			keys_q    <= keys_n;
			agree_q   <= agree_n;
			rnd_q     <= rnd_n;
			pres_q    <= pres_n;
			delay_q   <= delay_n;
			length_q  <= length_n;
			tone_on_q <= tone_on_n;
			tone_q    <= tone_n;
		end
	end

	// rows 8 and up shift out of the low byte and drive all ones
	assign sel       = ROWS_MAX'(1) << scan_n;
	assign scan_next = scan_n;

	always_comb begin
		result.row_drive    = ~sel[7:0];
		result.key_state    = keys_n;
		result.user_tick    = wrap;
		result.delay_left   = delay_n;
		result.tone_enable  = tone_on_n;
		result.tone_period  = tone_n;
		result.random_value = rnd_out;
	end

endmodule

// ===== rtl/led_scan_debounce_ticker_unit.sv =====
// ----------------------------------------------------------------------------
// led_scan_debounce_ticker_unit
// LED row scanner with two-key debounce, random byte, prescaled user tick,
// delay and tone-length countdowns.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | func, pin_sample, row_index, data_value,
//          |                      | tone_value
//  out     | out_valid / out_stall| row_drive, column_drive, key_state, user_tick,
//          |                      | delay_left, tone_enable, tone_period,
//          |                      | random_value
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One word per cycle while in_stall is low; a word taken is held in the read
//  stage (row memory read), then in the output register that drives the outputs.
//  State updates at acceptance, so the next word may follow at once.
//  Reset clears all control state and row valid bits; no clearing pass.
//  With the output stalled, one more word is taken into the read stage
//  before in_stall rises.
// ----------------------------------------------------------------------------
module led_scan_debounce_ticker_unit
	import lsd_pkg::*;
#(
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [1:0]  pin_sample,
	input  logic [2:0]  row_index,
	input  logic [7:0]  data_value,
	input  logic [7:0]  tone_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  row_drive,
	output logic [7:0]  column_drive,
	output logic [1:0]  key_state,
	output logic        user_tick,
	output logic [7:0]  delay_left,
	output logic        tone_enable,
	output logic [7:0]  tone_period,
	output logic [7:0]  random_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int AW = $clog2(ROWS);

	logic          accept, s1_adv;
	logic          valid_s1;
	lsd_result_t   res_s1;
	lsd_result_t   res_now;
	lsd_result_t   res_q;
	logic [7:0]    column_q;
	logic          out_valid_q;
	logic [AW-1:0] scan_next;
	logic [7:0]    rd_data;
	logic [4:0]    row_wide;
	logic          row_we;

	assign cfg_ready = 1'b1;

	// s1 moves on when the output register is empty or being emptied
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	assign row_wide = {2'b00, row_index};
	assign row_we   = accept && lsd_func_t'(func) == FUNC_WRITE_ROW &&
	                  32'(row_index) < ROWS;

	lsd_ctrl #(
		.ROWS(ROWS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.func       (func),
		.pin_sample (pin_sample),
		.data_value (data_value),
		.tone_value (tone_value),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_sel    (cfg_index),
		.cfg_data   (cfg_data),
		.scan_next  (scan_next),
		.result     (res_now)
	);

	lsd_row_mem #(
		.ROWS(ROWS)
	) u_row_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (row_we),
		.waddr  (row_wide[AW-1:0]),
		.wdata  (data_value),
		.re     (accept),
		.raddr  (scan_next),
		.rdata  (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q    <= res_s1;
			column_q <= rd_data;
		end
	end

	assign out_valid    = out_valid_q;
	assign row_drive    = res_q.row_drive;
	assign column_drive = column_q;
	assign key_state    = res_q.key_state;
	assign user_tick    = res_q.user_tick;
	assign delay_left   = res_q.delay_left;
	assign tone_enable  = res_q.tone_enable;
	assign tone_period  = res_q.tone_period;
	assign random_value = res_q.random_value;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled with room in the pipeline");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && out_stall) |=> valid_s1)
		else $error("read stage word lost while output stalled");

	a_row_one_cold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones(~row_drive) <= 1))
		else $error("row drive selects more than one row");
`endif

endmodule
